@@ hdl/circular_deque_with_search_assert.svh @@
// Assertion macros for the circular deque block.
// Included by circular_deque_with_search, which carries the concurrent checks; relies on clk and rst_n in scope.
`ifndef CIRCULAR_DEQUE_WITH_SEARCH_ASSERT_SVH
`define CIRCULAR_DEQUE_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// check sampled on clk, idle while reset is asserted
`define CDWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, also live during reset
`define CDWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDWS_ASSERT(label, prop, msg)
`define CDWS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hdl/cdws_pkg.sv @@
// Shared types and codes for the circular deque block.
// No dependencies.
package cdws_pkg;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_REM_FRONT = 3'd2;
  localparam logic [2:0] CMD_REM_BACK  = 3'd3;
  localparam logic [2:0] CMD_SEARCH    = 3'd4;
  localparam logic [2:0] CMD_COUNT     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } cdws_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] count;
  } cdws_out_t;

endpackage

@@ hdl/cdws_ram.sv @@
// Slot storage for the deque: one write port, one read port with registered data.
// No package dependencies.
module cdws_ram #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [31:0]                wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [31:0]                rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/circular_deque_with_search.sv @@
// Circular deque with linear search. Insert, remove and count: result in the cycle
// after the transaction is taken, next transaction may start that same cycle.
// Search of a nonempty deque: FILL reads the front slot, then SCAN compares one slot
// per cycle up to a match or the last stored slot. Empty one: result in the cycle after.
// Results strobe on out_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the deque; slot contents stay undefined.
module circular_deque_with_search
  import cdws_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  cdws_in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output cdws_out_t out_data
);

`include "circular_deque_with_search_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [31:0]   val_r, val_nxt;
  logic          out_valid_r, out_valid_nxt;
  cdws_out_t     out_r, out_nxt;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [AW:0]   back_sum;
  logic          last_cmp;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    ring_inc = (a == LAST_A) ? '0 : a + AW'(1);
  endfunction

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  // slot just past the back: front + count, unfolded; the back insert folds it once
  assign back_sum = {1'b0, front_r} + (AW+1)'(count_r);
  assign rd_addr  = (state_r == S_FILL) ? front_r : rd_ptr_r;
  assign last_cmp = ((CW'(cmp_idx_r) + CW'(1)) == count_r);

  cdws_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_idx_nxt   = cmp_idx_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_nxt.status  = ST_OK;
          out_nxt.found   = 1'b0;
          out_nxt.position = '0;
          unique case (in_data.cmd)
            CMD_INS_FRONT: begin
              if (count_r == DEPTH_C) begin
                out_nxt.status = ST_FULL;
              end else begin
                front_nxt = (front_r == '0) ? LAST_A : front_r - AW'(1);
                wr_en     = 1'b1;
                wr_addr   = front_nxt;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_INS_BACK: begin
              if (count_r == DEPTH_C) begin
                out_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = (back_sum >= (AW+1)'(DEPTH)) ?
                            AW'(back_sum - (AW+1)'(DEPTH)) : AW'(back_sum);
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_REM_FRONT: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                front_nxt = ring_inc(front_r);
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_REM_BACK: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_SEARCH: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                // result comes out of the scan instead
                out_valid_nxt = 1'b0;
                val_nxt       = in_data.value;
                cmp_idx_nxt   = '0;
                state_nxt     = S_FILL;
              end
            end
            default: begin
            end
          endcase
          out_nxt.count = 5'(count_nxt);
        end
      end
      S_FILL: begin
        rd_ptr_nxt = ring_inc(front_r);
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        // compare slot cmp_idx while the next one is read
        rd_ptr_nxt  = ring_inc(rd_ptr_r);
        cmp_idx_nxt = cmp_idx_r + AW'(1);
        if ((rd_data == val_r) || last_cmp) begin
          out_valid_nxt    = 1'b1;
          out_nxt.status   = ST_OK;
          out_nxt.found    = (rd_data == val_r);
          out_nxt.position = (rd_data == val_r) ? 4'(cmp_idx_r) : 4'd0;
          out_nxt.count    = 5'(count_r);
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r  <= rd_ptr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    val_r     <= val_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CDWS_ASSERT(a_count_bound, count_r <= DEPTH_C, "stored count exceeds depth")
  `CDWS_ASSERT(a_scan_end_result, $fell(busy) |-> out_valid, "scan ended without a result")
  `CDWS_ASSERT(a_found_ok, out_valid && out_data.found |-> out_data.status == ST_OK, "found with bad status")
  `CDWS_ASSERT(a_scan_holds_count, (state_r == S_SCAN) |=> $stable(count_r), "count moved during scan")
  `CDWS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for circular_deque_with_search: a directed table, then random
// command streams with idle gaps; results checked against fixed table values or a deque predictor.
// Depends on cdws_pkg and the circular_deque_with_search RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdws_pkg::*;

  localparam int DEPTH = 16;
  localparam int RAND_ITEMS = 1420;
  localparam int QUIET_TAIL = 200;      // last random items run without idle gaps
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int NUM_ROWS = 17;

  // one directed row: command, value, repeat count, and an optional fixed result
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         reps;
    logic               fixed;
    cdws_out_t          result;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  cdws_in_t  in_data;
  logic      busy;
  logic      out_valid;
  cdws_out_t out_data;

  // predictor state
  logic signed [31:0] ring_slots [DEPTH];
  logic [3:0]         ring_front;
  logic [4:0]         ring_count;

  cdws_out_t pending_results [$];
  cdws_out_t want;
  int        failures;
  int        cycle_cnt;
  bit        gaps_on;
  dir_row_t  dir_rows [NUM_ROWS];

  circular_deque_with_search #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Applies one command to the predicted deque and returns the result it yields.
  function automatic cdws_out_t deque_apply(input cdws_in_t c);
    cdws_out_t  r;
    logic [3:0] idx;
    r = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_INS_FRONT: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_front = ring_front - 4'd1;
          ring_slots[ring_front] = c.value;
          ring_count = ring_count + 5'd1;
        end
      end
      CMD_INS_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          idx = ring_front + ring_count[3:0];
          ring_slots[idx] = c.value;
          ring_count = ring_count + 5'd1;
        end
      end
      CMD_REM_FRONT: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_front = ring_front + 4'd1;
          ring_count = ring_count - 5'd1;
        end
      end
      CMD_REM_BACK: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else ring_count = ring_count - 5'd1;
      end
      CMD_SEARCH: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            idx = ring_front + 4'(i);
            if (!r.found && ring_slots[idx] == c.value) begin
              r.found = 1'b1;
              r.position = 4'(i);
            end
          end
        end
      end
      default: ;
    endcase
    r.count = ring_count;
    return r;
  endfunction

  // Holds one command on the input until taken, records its expected result,
  // then maybe idles the input for a burst.
  task automatic issue_cmd(input cdws_in_t item, input logic fixed, input cdws_out_t fixed_res);
    cdws_out_t pred;
    cdws_in_t  junk;
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    pred = deque_apply(item);
    pending_results.push_back(fixed ? fixed_res : pred);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      junk.cmd = 3'($urandom);
      junk.value = $urandom;
      start <= 1'b0;
      in_data <= junk;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction pending: %p", out_data);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_data.found);
          failures++;
        end
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_data.position);
          failures++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          failures++;
        end
      end
    end
  end

  initial begin
    cdws_in_t   item;
    dir_row_t   row;
    int         bias;
    int         roll;
    int         grow_pct;
    logic [3:0] idx;

    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    gaps_on = 1'b1;
    ring_front = '0;
    ring_count = '0;
    for (int i = 0; i < DEPTH; i++) ring_slots[i] = '0;

    dir_rows = '{
      '{CMD_COUNT,     32'sd0,          5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd0}},
      '{CMD_REM_FRONT, 32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 1'b0, 4'd0,  5'd0}},
      '{CMD_REM_BACK,  32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 1'b0, 4'd0,  5'd0}},
      '{CMD_SEARCH,    32'sd0,          5'd1,  1'b1, '{ST_EMPTY, 1'b0, 4'd0,  5'd0}},
      '{CMD_SPARE_HI,  32'sd0,          5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd0}},
      '{CMD_INS_BACK,  32'h7FFF_FFFF,   5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd1}},
      // front insert from index zero wraps the ring
      '{CMD_INS_FRONT, 32'h8000_0000,   5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd2}},
      '{CMD_SEARCH,    32'h7FFF_FFFF,   5'd1,  1'b1, '{ST_OK,    1'b1, 4'd1,  5'd2}},
      '{CMD_SEARCH,    -32'sd1,         5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd2}},
      '{CMD_INS_BACK,  32'sd5,          5'd13, 1'b0, '0},
      '{CMD_INS_BACK,  32'sd12345,      5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd16}},
      '{CMD_INS_FRONT, 32'sd1,          5'd1,  1'b1, '{ST_FULL,  1'b0, 4'd0,  5'd16}},
      '{CMD_INS_BACK,  32'sd1,          5'd1,  1'b1, '{ST_FULL,  1'b0, 4'd0,  5'd16}},
      // match in the very last slot
      '{CMD_SEARCH,    32'sd12345,      5'd1,  1'b1, '{ST_OK,    1'b1, 4'd15, 5'd16}},
      '{CMD_SEARCH,    32'sd5,          5'd1,  1'b1, '{ST_OK,    1'b1, 4'd2,  5'd16}},
      '{CMD_REM_FRONT, 32'sd0,          5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd15}},
      '{CMD_REM_BACK,  32'sd0,          5'd1,  1'b1, '{ST_OK,    1'b0, 4'd0,  5'd14}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      item.cmd = row.cmd;
      item.value = row.value;
      for (int k = 0; k < row.reps; k++) issue_cmd(item, row.fixed, row.result);
    end

    bias = 2;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // pick growing, shrinking or balanced phases at random so full and empty are both hit
      if (n % 48 == 0) bias = $urandom_range(0, 2);
      if (n % 120 == 0) gaps_on = (n < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
      if (n == RAND_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      grow_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;

      case ($urandom_range(0, 3))
        0: item.value = $urandom;
        1: item.value = $urandom_range(0, 7);
        2: item.value = -$signed(32'($urandom_range(1, 8)));
        default: begin
          roll = $urandom_range(0, 3);
          item.value = (roll == 0) ? 32'h7FFF_FFFF : (roll == 1) ? 32'h8000_0000 :
                       (roll == 2) ? 32'sd0 : -32'sd1;
        end
      endcase

      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        item.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end else if (roll < 30) begin
        item.cmd = CMD_SEARCH;
        if (ring_count != 0 && $urandom_range(0, 3) != 0) begin
          idx = ring_front + 4'($urandom_range(0, ring_count - 1));
          item.value = ring_slots[idx];
        end
      end else if (roll < 36) begin
        item.cmd = CMD_COUNT;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        item.cmd = $urandom_range(0, 1) ? CMD_INS_FRONT : CMD_INS_BACK;
      end else begin
        item.cmd = $urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK;
      end
      issue_cmd(item, 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
